[rtl/snfcs_pkg.sv]
// ============================================================================
// Serial NOR flash command sequencer package
// Shared widths, codes, word types and frame helper functions.
// ============================================================================
package snfcs_pkg;

    localparam int ADDR_W = 24;
    localparam int LEN_W  = 16;
    localparam int BYTE_W = 8;
    localparam int ACT_W  = 3;
    localparam int POS_W  = 3;

    localparam int PAGE_BYTES_DEFAULT = 256;

    // Flash opcodes and fixed bytes
    localparam logic [BYTE_W-1:0] OPC_WREN   = 8'h06;
    localparam logic [BYTE_W-1:0] OPC_PROG   = 8'h02;
    localparam logic [BYTE_W-1:0] OPC_READ   = 8'h03;
    localparam logic [BYTE_W-1:0] OPC_RDSR   = 8'h05;
    localparam logic [BYTE_W-1:0] OPC_SE     = 8'h20;
    localparam logic [BYTE_W-1:0] OPC_CE     = 8'hC7;
    localparam logic [BYTE_W-1:0] OPC_JEDEC  = 8'h9F;
    localparam logic [BYTE_W-1:0] OPC_MFR    = 8'h90;
    localparam logic [BYTE_W-1:0] BYTE_DUMMY = 8'hFF;
    localparam logic [BYTE_W-1:0] BYTE_ZERO  = 8'h00;
    localparam int                WIP_BIT    = 0;

    // Last header position for four-byte and one-byte headers
    localparam logic [POS_W-1:0] POS_FIRST = 3'd0;
    localparam logic [POS_W-1:0] POS_ADDR1 = 3'd1;
    localparam logic [POS_W-1:0] POS_ADDR2 = 3'd2;
    localparam logic [POS_W-1:0] POS_ADDR3 = 3'd3;

    // ID byte counts
    localparam logic [POS_W-1:0] ID_BYTES_MFR   = 3'd2;
    localparam logic [POS_W-1:0] ID_BYTES_JEDEC = 3'd3;

    typedef enum logic [ACT_W-1:0] {
        ACT_READ        = 3'd0,
        ACT_PROG        = 3'd1,
        ACT_SE          = 3'd2,
        ACT_CE          = 3'd3,
        ACT_MFR         = 3'd4,
        ACT_JEDEC       = 3'd5,
        ACT_HOST_DATA   = 3'd6,
        ACT_FLASH_REPLY = 3'd7
    } action_t;

    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_WREN      = 4'd1,
        PH_HEAD      = 4'd2,
        PH_DATA_WAIT = 4'd3,
        PH_DATA_SENT = 4'd4,
        PH_READ      = 4'd5,
        PH_POLL_CMD  = 4'd6,
        PH_POLL_STAT = 4'd7,
        PH_ID        = 4'd8
    } phase_t;

    typedef struct packed {
        action_t             action;
        logic [ADDR_W-1:0]   address;
        logic [LEN_W-1:0]    length;
        logic [BYTE_W-1:0]   host_byte;
        logic [BYTE_W-1:0]   flash_byte;
    } cmd_item_t;

    typedef struct packed {
        logic                send_valid;
        logic [BYTE_W-1:0]   out_byte;
        logic                frame_end;
        logic                want_data;
        logic                read_valid;
        logic [BYTE_W-1:0]   read_byte;
        logic                id_valid;
        logic [ADDR_W-1:0]   id_value;
        logic                done_res;
        logic                rejected;
    } rsp_item_t;

    // True when position k is the last byte of the command header.
    function automatic logic head_last(action_t op, logic [POS_W-1:0] k);
        logic short_head;
        short_head = (op == ACT_CE) || (op == ACT_JEDEC);
        return short_head ? (k == POS_FIRST) : (k == POS_ADDR3);
    endfunction

    // True when the header is a whole frame by itself.
    function automatic logic head_ends(action_t op, logic [LEN_W-1:0] bytes_left);
        return (op == ACT_SE) || (op == ACT_CE) ||
               ((op == ACT_READ) && (bytes_left == '0));
    endfunction

    function automatic logic [BYTE_W-1:0] head_byte(action_t op, logic [POS_W-1:0] k,
                                                    logic [ADDR_W-1:0] addr);
        logic [BYTE_W-1:0] b;
        b = addr[7:0];
        if (k == POS_FIRST) begin
            unique case (op)
                ACT_READ:  b = OPC_READ;
                ACT_PROG:  b = OPC_PROG;
                ACT_SE:    b = OPC_SE;
                ACT_CE:    b = OPC_CE;
                ACT_MFR:   b = OPC_MFR;
                default:   b = OPC_JEDEC;
            endcase
        end
        else if (op == ACT_MFR) begin
            b = BYTE_ZERO;
        end
        else if (k == POS_ADDR1) begin
            b = addr[23:16];
        end
        else if (k == POS_ADDR2) begin
            b = addr[15:8];
        end
        return b;
    endfunction

endpackage

[rtl/snfcs_stream_if.sv]
// ============================================================================
// Valid/ready word channel
// Carries one word of type T from a source to a sink.
// ============================================================================
interface snfcs_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/snfcs_page_mod.sv]
// ============================================================================
// Page offset unit
// Finds address modulo the page size by reciprocal multiplication.
// ============================================================================
module snfcs_page_mod #(
    parameter int PAGE_BYTES = snfcs_pkg::PAGE_BYTES_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           load,
    input  logic [snfcs_pkg::ADDR_W-1:0]   value,
    output logic [$clog2(PAGE_BYTES)-1:0]  offset
);
    localparam int AW = snfcs_pkg::ADDR_W;
    localparam int RW = $clog2(PAGE_BYTES);
    localparam int SH = AW + RW;
    localparam int MW = 2 * AW + 1;
    localparam int QW = MW - SH;

    // Rounded-up reciprocal of the page size. With a post-shift of AW plus
    // the page size's bit count, the quotient is exact for every address.
    localparam longint unsigned RECIP =
        ((64'd1 << SH) + 64'(PAGE_BYTES) - 64'd1) / 64'(PAGE_BYTES);

    logic [AW-1:0] value_reg;
    logic [AW-1:0] held_reg;
    logic [QW-1:0] quot_reg;
    logic [RW-1:0] rem_reg;
    logic [MW-1:0] product;
    logic [AW-1:0] whole;

    // The address is 24 bits and the reciprocal 25 bits; the upper bits of
    // the product are the quotient.
    assign product = MW'(value_reg) * MW'(RECIP);
    assign whole   = AW'(quot_reg) * AW'(PAGE_BYTES);

    // A load passes through the address register, then the quotient register,
    // then the remainder register that drives the offset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg <= '0;
            held_reg  <= '0;
            quot_reg  <= '0;
            rem_reg   <= '0;
        end
        else
        begin
            if (load)
            begin
                value_reg <= value;
            end
            held_reg <= value_reg;
            quot_reg <= product[MW-1:SH];
            rem_reg  <= RW'(held_reg - whole);
        end
    end

    assign offset = rem_reg;
endmodule

[rtl/snfcs_core.sv]
// ============================================================================
// Sequencer core
// Operation state and the single-pass step logic for one word.
// ============================================================================
module snfcs_core #(
    parameter int PAGE_BYTES = snfcs_pkg::PAGE_BYTES_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  snfcs_pkg::cmd_item_t  item,
    output snfcs_pkg::rsp_item_t  result
);
    localparam int RW = $clog2(PAGE_BYTES);
    localparam int PW = $clog2(PAGE_BYTES + 1);
    localparam int AW = snfcs_pkg::ADDR_W;
    localparam int LW = snfcs_pkg::LEN_W;
    localparam int FW = snfcs_pkg::POS_W;

    snfcs_pkg::phase_t   phase_reg, phase_next;
    snfcs_pkg::action_t  op_reg, op_next;
    logic [AW-1:0]       cursor_reg, cursor_next;
    logic                cursor_we;
    logic [LW-1:0]       bytes_reg, bytes_next;
    logic [PW-1:0]       page_reg, page_next;
    logic                fresh_reg, fresh_next;
    logic [FW-1:0]       pos_reg, pos_next;
    logic [AW-1:0]       acc_reg, acc_next;

    logic [RW-1:0]       offset;
    logic [PW-1:0]       room;
    logic [PW-1:0]       page_eff;
    logic [LW-1:0]       bytes_dec;
    logic [AW-1:0]       acc_shift;
    logic [FW-1:0]       id_need;
    logic                is_req;
    logic                head_done;
    logic [LW-1:0]       req_len;

    snfcs_page_mod #(
        .PAGE_BYTES (PAGE_BYTES)
    ) u_page (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (step && cursor_we),
        .value  (cursor_next),
        .offset (offset)
    );

    // Room left in the page; the first page of a program takes it from the
    // offset unit, which has settled long before the first data word.
    assign room      = PW'(PAGE_BYTES) - PW'(offset);
    assign page_eff  = !fresh_reg ? page_reg :
                       (bytes_reg < LW'(room)) ? bytes_reg[PW-1:0] : room;
    assign bytes_dec = bytes_reg - LW'(1);
    assign acc_shift = {acc_reg[AW-9:0], item.flash_byte};
    assign id_need   = (op_reg == snfcs_pkg::ACT_MFR) ? snfcs_pkg::ID_BYTES_MFR
                                                      : snfcs_pkg::ID_BYTES_JEDEC;
    assign is_req    = (item.action != snfcs_pkg::ACT_HOST_DATA) &&
                       (item.action != snfcs_pkg::ACT_FLASH_REPLY);
    assign head_done = snfcs_pkg::head_last(op_reg, pos_reg);
    assign req_len   = ((item.action == snfcs_pkg::ACT_READ) ||
                        (item.action == snfcs_pkg::ACT_PROG)) ? item.length : '0;

    // Next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (is_req)
        begin
            if (phase_reg == snfcs_pkg::PH_IDLE)
            begin
                if (item.action == snfcs_pkg::ACT_PROG && item.length == '0)
                    phase_next = snfcs_pkg::PH_IDLE;
                else if (item.action == snfcs_pkg::ACT_PROG ||
                         item.action == snfcs_pkg::ACT_SE ||
                         item.action == snfcs_pkg::ACT_CE)
                    phase_next = snfcs_pkg::PH_WREN;
                else
                    phase_next = snfcs_pkg::PH_HEAD;
            end
        end
        else if (item.action == snfcs_pkg::ACT_HOST_DATA)
        begin
            if (phase_reg == snfcs_pkg::PH_DATA_WAIT)
                phase_next = snfcs_pkg::PH_DATA_SENT;
        end
        else
        begin
            unique case (phase_reg)
                snfcs_pkg::PH_WREN:
                    phase_next = snfcs_pkg::PH_HEAD;
                snfcs_pkg::PH_HEAD:
                begin
                    if (!head_done)
                        phase_next = snfcs_pkg::PH_HEAD;
                    else if (op_reg == snfcs_pkg::ACT_READ)
                        phase_next = (bytes_reg == '0) ? snfcs_pkg::PH_IDLE
                                                       : snfcs_pkg::PH_READ;
                    else if (op_reg == snfcs_pkg::ACT_PROG)
                        phase_next = snfcs_pkg::PH_DATA_WAIT;
                    else if (op_reg == snfcs_pkg::ACT_SE || op_reg == snfcs_pkg::ACT_CE)
                        phase_next = snfcs_pkg::PH_POLL_CMD;
                    else
                        phase_next = snfcs_pkg::PH_ID;
                end
                snfcs_pkg::PH_READ:
                    phase_next = (bytes_dec == '0) ? snfcs_pkg::PH_IDLE
                                                   : snfcs_pkg::PH_READ;
                snfcs_pkg::PH_DATA_SENT:
                    phase_next = (page_reg != '0) ? snfcs_pkg::PH_DATA_WAIT
                                                  : snfcs_pkg::PH_POLL_CMD;
                snfcs_pkg::PH_POLL_CMD:
                    phase_next = snfcs_pkg::PH_POLL_STAT;
                snfcs_pkg::PH_POLL_STAT:
                begin
                    if (item.flash_byte[snfcs_pkg::WIP_BIT])
                        phase_next = snfcs_pkg::PH_POLL_CMD;
                    else if (op_reg == snfcs_pkg::ACT_PROG && bytes_reg != '0)
                        phase_next = snfcs_pkg::PH_WREN;
                    else
                        phase_next = snfcs_pkg::PH_IDLE;
                end
                snfcs_pkg::PH_ID:
                    phase_next = (pos_reg < id_need) ? snfcs_pkg::PH_ID
                                                     : snfcs_pkg::PH_IDLE;
                default:
                    phase_next = phase_reg;
            endcase
        end
    end

    // Result word and datapath updates
    always_comb
    begin
        result      = '0;
        op_next     = op_reg;
        cursor_next = cursor_reg;
        cursor_we   = 1'b0;
        bytes_next  = bytes_reg;
        page_next   = page_reg;
        fresh_next  = fresh_reg;
        pos_next    = pos_reg;
        acc_next    = acc_reg;

        if (is_req)
        begin
            if (phase_reg != snfcs_pkg::PH_IDLE)
            begin
                result.rejected = 1'b1;
            end
            else
            begin
                op_next     = item.action;
                cursor_next = item.address;
                cursor_we   = 1'b1;
                bytes_next  = req_len;
                page_next   = '0;
                fresh_next  = 1'b0;
                acc_next    = '0;
                if (item.action == snfcs_pkg::ACT_PROG && item.length == '0)
                begin
                    result.done_res = 1'b1;
                end
                else if (item.action == snfcs_pkg::ACT_PROG ||
                         item.action == snfcs_pkg::ACT_SE ||
                         item.action == snfcs_pkg::ACT_CE)
                begin
                    fresh_next        = (item.action == snfcs_pkg::ACT_PROG);
                    result.send_valid = 1'b1;
                    result.out_byte   = snfcs_pkg::OPC_WREN;
                    result.frame_end  = 1'b1;
                end
                else
                begin
                    pos_next          = snfcs_pkg::POS_FIRST;
                    result.send_valid = 1'b1;
                    result.out_byte   = snfcs_pkg::head_byte(item.action,
                                            snfcs_pkg::POS_FIRST, item.address);
                    result.frame_end  = snfcs_pkg::head_last(item.action,
                                            snfcs_pkg::POS_FIRST) &&
                                        snfcs_pkg::head_ends(item.action, req_len);
                end
            end
        end
        else if (item.action == snfcs_pkg::ACT_HOST_DATA)
        begin
            if (phase_reg == snfcs_pkg::PH_DATA_WAIT)
            begin
                result.send_valid = 1'b1;
                result.out_byte   = item.host_byte;
                result.frame_end  = (page_eff == PW'(1));
                page_next         = page_eff - PW'(1);
                fresh_next        = 1'b0;
                bytes_next        = bytes_dec;
                cursor_next       = cursor_reg + AW'(1);
                cursor_we         = 1'b1;
            end
        end
        else
        begin
            unique case (phase_reg)
                snfcs_pkg::PH_WREN:
                begin
                    pos_next          = snfcs_pkg::POS_FIRST;
                    result.send_valid = 1'b1;
                    result.out_byte   = snfcs_pkg::head_byte(op_reg, snfcs_pkg::POS_FIRST,
                                                             cursor_reg);
                    result.frame_end  = snfcs_pkg::head_last(op_reg, snfcs_pkg::POS_FIRST) &&
                                        snfcs_pkg::head_ends(op_reg, bytes_reg);
                end
                snfcs_pkg::PH_HEAD:
                begin
                    if (!head_done)
                    begin
                        pos_next          = pos_reg + FW'(1);
                        result.send_valid = 1'b1;
                        result.out_byte   = snfcs_pkg::head_byte(op_reg, pos_reg + FW'(1),
                                                                 cursor_reg);
                        result.frame_end  = snfcs_pkg::head_last(op_reg, pos_reg + FW'(1)) &&
                                            snfcs_pkg::head_ends(op_reg, bytes_reg);
                    end
                    else if (op_reg == snfcs_pkg::ACT_READ)
                    begin
                        if (bytes_reg == '0)
                        begin
                            result.done_res = 1'b1;
                        end
                        else
                        begin
                            result.send_valid = 1'b1;
                            result.out_byte   = snfcs_pkg::BYTE_DUMMY;
                            result.frame_end  = (bytes_reg == LW'(1));
                        end
                    end
                    else if (op_reg == snfcs_pkg::ACT_PROG)
                    begin
                        result.want_data = 1'b1;
                    end
                    else if (op_reg == snfcs_pkg::ACT_SE || op_reg == snfcs_pkg::ACT_CE)
                    begin
                        result.send_valid = 1'b1;
                        result.out_byte   = snfcs_pkg::OPC_RDSR;
                    end
                    else
                    begin
                        pos_next          = snfcs_pkg::POS_ADDR1;
                        result.send_valid = 1'b1;
                        result.out_byte   = snfcs_pkg::BYTE_DUMMY;
                        result.frame_end  = (id_need == snfcs_pkg::POS_ADDR1);
                    end
                end
                snfcs_pkg::PH_READ:
                begin
                    result.read_valid = 1'b1;
                    result.read_byte  = item.flash_byte;
                    bytes_next        = bytes_dec;
                    cursor_next       = cursor_reg + AW'(1);
                    cursor_we         = 1'b1;
                    if (bytes_dec == '0)
                    begin
                        result.done_res = 1'b1;
                    end
                    else
                    begin
                        result.send_valid = 1'b1;
                        result.out_byte   = snfcs_pkg::BYTE_DUMMY;
                        result.frame_end  = (bytes_dec == LW'(1));
                    end
                end
                snfcs_pkg::PH_DATA_SENT:
                begin
                    if (page_reg != '0)
                    begin
                        result.want_data = 1'b1;
                    end
                    else
                    begin
                        result.send_valid = 1'b1;
                        result.out_byte   = snfcs_pkg::OPC_RDSR;
                    end
                end
                snfcs_pkg::PH_POLL_CMD:
                begin
                    result.send_valid = 1'b1;
                    result.out_byte   = snfcs_pkg::BYTE_DUMMY;
                    result.frame_end  = 1'b1;
                end
                snfcs_pkg::PH_POLL_STAT:
                begin
                    if (item.flash_byte[snfcs_pkg::WIP_BIT])
                    begin
                        result.send_valid = 1'b1;
                        result.out_byte   = snfcs_pkg::OPC_RDSR;
                    end
                    else if (op_reg == snfcs_pkg::ACT_PROG && bytes_reg != '0)
                    begin
                        // Later pages start on a page boundary; the offset
                        // unit still recomputes the room from the cursor.
                        fresh_next        = 1'b1;
                        result.send_valid = 1'b1;
                        result.out_byte   = snfcs_pkg::OPC_WREN;
                        result.frame_end  = 1'b1;
                    end
                    else
                    begin
                        result.done_res = 1'b1;
                    end
                end
                snfcs_pkg::PH_ID:
                begin
                    acc_next = acc_shift;
                    if (pos_reg < id_need)
                    begin
                        pos_next          = pos_reg + FW'(1);
                        result.send_valid = 1'b1;
                        result.out_byte   = snfcs_pkg::BYTE_DUMMY;
                        result.frame_end  = ((pos_reg + FW'(1)) == id_need);
                    end
                    else
                    begin
                        result.id_valid = 1'b1;
                        result.id_value = (op_reg == snfcs_pkg::ACT_MFR) ?
                                          {8'h00, acc_shift[15:0]} : acc_shift;
                        result.done_res = 1'b1;
                    end
                end
                default:
                begin
                    result = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= snfcs_pkg::PH_IDLE;
            op_reg     <= snfcs_pkg::ACT_READ;
            cursor_reg <= '0;
            bytes_reg  <= '0;
            page_reg   <= '0;
            fresh_reg  <= 1'b0;
            pos_reg    <= '0;
            acc_reg    <= '0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            op_reg     <= op_next;
            cursor_reg <= cursor_next;
            bytes_reg  <= bytes_next;
            page_reg   <= page_next;
            fresh_reg  <= fresh_next;
            pos_reg    <= pos_next;
            acc_reg    <= acc_next;
        end
    end
endmodule

[rtl/serial_nor_flash_command_sequencer.sv]
// ============================================================================
// Serial NOR flash command sequencer
// Turns host requests and flash reply bytes into the next byte to shift out,
// with frame ends, read data, ID values and completion flags.
// ============================================================================
//
//  Channel  Dir  Word type   Contents
//  -------  ---  ----------  ----------------------------------------------
//  cmd      in   cmd_item_t  host request, host data byte or flash reply
//  rsp      out  rsp_item_t  next flash byte, frame end, read/ID data, flags
//
// Every cmd word produces exactly one rsp word. The block takes one word
// per cycle while rsp is not holding it off: an input register holds the
// word, and the step logic updates the operation state and fills the
// output register as the word leaves, so a new word can follow at once.
// rsp backpressure stalls the input register only when the output register
// is full and not being drained. Reset is asynchronous, active low, and
// returns the sequencer to idle with no words in flight.
//
module serial_nor_flash_command_sequencer #(
    parameter int PAGE_BYTES = snfcs_pkg::PAGE_BYTES_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    snfcs_stream_if.sink   cmd,
    snfcs_stream_if.source rsp
);
    // Input register stage.
    logic                  in_valid_reg;
    snfcs_pkg::cmd_item_t  in_item_reg;

    // Output register stage.
    logic                  out_valid_reg;
    snfcs_pkg::rsp_item_t  out_item_reg;

    // Step result from the core for the word in the input register.
    snfcs_pkg::rsp_item_t  step_result;
    logic                  out_free;
    logic                  advance;
    logic                  take;

    // The output register can load when it is empty or being drained; the
    // input word then advances and the state moves on in the same cycle.
    assign out_free  = !out_valid_reg || rsp.ready;
    assign advance   = in_valid_reg && out_free;
    assign cmd.ready = !in_valid_reg || out_free;
    assign take      = cmd.valid && cmd.ready;

    snfcs_core #(
        .PAGE_BYTES (PAGE_BYTES)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (in_item_reg),
        .result (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (take)
            in_item_reg <= cmd.data;
        if (advance)
            out_item_reg <= step_result;
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_item_reg;
endmodule

[rtl/snfcs_checker.sv]
// ============================================================================
// Sequencer port checker
// Watches the response channel for consistent result words.
// ============================================================================
module snfcs_checker (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  rsp_valid,
    input  logic                  rsp_ready,
    input  snfcs_pkg::rsp_item_t  rsp_data
);
    // A stalled result word holds.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
        else $error("rsp word changed while stalled");

    // Without send_valid, out_byte is zero and frame_end is low.
    a_send_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_data.send_valid |->
            rsp_data.out_byte == '0 && !rsp_data.frame_end)
        else $error("out_byte or frame_end set without send_valid");

    // Sending, asking for data, finishing and rejecting exclude one another.
    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> $onehot0({rsp_data.send_valid, rsp_data.want_data,
                                rsp_data.done_res, rsp_data.rejected}))
        else $error("conflicting result flags");

    // A finished ID is the end of its operation and carries nothing else.
    a_id_done: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.id_valid |->
            rsp_data.done_res && !rsp_data.read_valid)
        else $error("id_valid without done_res");
endmodule

bind serial_nor_flash_command_sequencer snfcs_checker u_snfcs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_data  (rsp.data)
);

[tb/tb_top.sv]
// ============================================================================
// Serial NOR flash command sequencer testbench
// Plays both the host and the flash. Request, host data and flash reply words
// go in through the cmd channel, and every accepted word is run through a
// behavioral model of the sequencer to predict its rsp word. A checker
// compares each rsp word, field by field, with the oldest prediction.
// ============================================================================
module tb_top;

    import snfcs_pkg::*;

    localparam int PAGE = PAGE_BYTES_DEFAULT;

    // The slowest correct run has well under two thousand words, each costing at
    // most the sender's longest random gap, the input and output registers and
    // the receiver's longest stall. The limit is many times that figure.
    localparam int CYCLE_LIMIT = 400000;

    logic clk = 1'b0;
    logic rst_n;

    snfcs_stream_if #(.T(cmd_item_t)) cmd_ch ();
    snfcs_stream_if #(.T(rsp_item_t)) rsp_ch ();

    serial_nor_flash_command_sequencer #(
        .PAGE_BYTES(PAGE)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch)
    );

    always #5 clk = ~clk;

    // Idling knobs. The two _pct knobs give the chance, in percent, that a side
    // idles in a given cycle. hold_left forces a long receiver stall.
    int src_idle_pct  = 0;
    int sink_idle_pct = 0;
    int hold_left     = 0;

    int cycles     = 0;
    int mismatches = 0;
    int work_words = 0;

    // Predicted rsp words, oldest first.
    rsp_item_t rsp_due[$];
    rsp_item_t rsp_seen;
    rsp_item_t rsp_want;

    // ------------------------------------------------------------------------
    // Sequencer model state. These variables track the operation in flight
    // exactly as the block is expected to, starting from the reset state.
    // ------------------------------------------------------------------------
    phase_t      fl_phase = PH_IDLE;
    action_t     fl_op    = ACT_READ;
    logic [23:0] fl_addr  = '0;
    logic [15:0] fl_left  = '0;
    logic [10:0] fl_page  = '0;
    logic [2:0]  fl_pos   = '0;
    logic [23:0] fl_id    = '0;
    rsp_item_t   fl_rsp;

    // Marks fl_rsp as carrying a byte for the flash.
    function automatic void put_byte(logic [7:0] b, logic last);
        fl_rsp.send_valid = 1'b1;
        fl_rsp.out_byte   = b;
        fl_rsp.frame_end  = last;
    endfunction

    function automatic int hdr_len();
        return (fl_op == ACT_CE || fl_op == ACT_JEDEC) ? 1 : 4;
    endfunction

    function automatic int id_len();
        return (fl_op == ACT_MFR) ? 2 : 3;
    endfunction

    // Sends byte k of the command header. The manufacturer ID command takes
    // three zero bytes where the others carry the address. The header is a
    // frame of its own for erases and for a read of zero bytes.
    function automatic void send_hdr(int k);
        logic [7:0] b;
        logic       closes;
        if (k == 0)
        begin
            case (fl_op)
                ACT_READ: b = OPC_READ;
                ACT_PROG: b = OPC_PROG;
                ACT_SE:   b = OPC_SE;
                ACT_CE:   b = OPC_CE;
                ACT_MFR:  b = OPC_MFR;
                default:  b = OPC_JEDEC;
            endcase
        end
        else if (fl_op == ACT_MFR)
        begin
            b = BYTE_ZERO;
        end
        else if (k == 1)
        begin
            b = fl_addr[23:16];
        end
        else if (k == 2)
        begin
            b = fl_addr[15:8];
        end
        else
        begin
            b = fl_addr[7:0];
        end
        closes = (fl_op == ACT_SE) || (fl_op == ACT_CE) ||
                 (fl_op == ACT_READ && fl_left == '0);
        fl_pos   = k[2:0];
        fl_phase = PH_HEAD;
        put_byte(b, (k + 1 == hdr_len()) && closes);
    endfunction

    // A program page never crosses a page boundary, so the page holds
    // whatever is left or the room up to the boundary, whichever is less.
    function automatic void open_page();
        int room;
        room     = PAGE - (fl_addr % PAGE);
        fl_page  = (int'(fl_left) < room) ? 11'(fl_left) : 11'(room);
        fl_phase = PH_WREN;
        put_byte(OPC_WREN, 1'b1);
    endfunction

    function automatic void finish_op();
        fl_rsp.done_res = 1'b1;
        fl_phase        = PH_IDLE;
    endfunction

    // Predicts the rsp word for one accepted cmd word and moves the model on.
    function automatic rsp_item_t sequence_step(cmd_item_t c);
        fl_rsp = '0;
        if (c.action <= ACT_JEDEC)
        begin
            // A new request is refused while anything is running.
            if (fl_phase != PH_IDLE)
            begin
                fl_rsp.rejected = 1'b1;
            end
            else
            begin
                fl_op   = c.action;
                fl_addr = c.address;
                fl_left = (c.action == ACT_READ || c.action == ACT_PROG) ? c.length : '0;
                fl_page = '0;
                fl_id   = '0;
                if (c.action == ACT_PROG)
                begin
                    if (fl_left == '0)
                    begin
                        finish_op();
                    end
                    else
                    begin
                        open_page();
                    end
                end
                else if (c.action == ACT_SE || c.action == ACT_CE)
                begin
                    fl_phase = PH_WREN;
                    put_byte(OPC_WREN, 1'b1);
                end
                else
                begin
                    send_hdr(0);
                end
            end
        end
        else if (c.action == ACT_HOST_DATA)
        begin
            // Host data only counts while the block waits for it.
            if (fl_phase == PH_DATA_WAIT)
            begin
                put_byte(c.host_byte, fl_page == 11'd1);
                fl_page  = fl_page - 11'd1;
                fl_left  = fl_left - 16'd1;
                fl_addr  = fl_addr + 24'd1;
                fl_phase = PH_DATA_SENT;
            end
        end
        else
        begin
            case (fl_phase)
                PH_WREN:
                begin
                    send_hdr(0);
                end
                PH_HEAD:
                begin
                    if (fl_pos + 1 < hdr_len())
                    begin
                        send_hdr(fl_pos + 1);
                    end
                    else if (fl_op == ACT_READ)
                    begin
                        if (fl_left == '0)
                        begin
                            finish_op();
                        end
                        else
                        begin
                            fl_phase = PH_READ;
                            put_byte(BYTE_DUMMY, fl_left == 16'd1);
                        end
                    end
                    else if (fl_op == ACT_PROG)
                    begin
                        fl_rsp.want_data = 1'b1;
                        fl_phase         = PH_DATA_WAIT;
                    end
                    else if (fl_op == ACT_SE || fl_op == ACT_CE)
                    begin
                        fl_phase = PH_POLL_CMD;
                        put_byte(OPC_RDSR, 1'b0);
                    end
                    else
                    begin
                        fl_pos   = 3'd1;
                        fl_phase = PH_ID;
                        put_byte(BYTE_DUMMY, id_len() == 1);
                    end
                end
                PH_READ:
                begin
                    fl_rsp.read_valid = 1'b1;
                    fl_rsp.read_byte  = c.flash_byte;
                    fl_left = fl_left - 16'd1;
                    fl_addr = fl_addr + 24'd1;
                    if (fl_left == '0)
                    begin
                        finish_op();
                    end
                    else
                    begin
                        put_byte(BYTE_DUMMY, fl_left == 16'd1);
                    end
                end
                PH_DATA_SENT:
                begin
                    if (fl_page != '0)
                    begin
                        fl_rsp.want_data = 1'b1;
                        fl_phase         = PH_DATA_WAIT;
                    end
                    else
                    begin
                        fl_phase = PH_POLL_CMD;
                        put_byte(OPC_RDSR, 1'b0);
                    end
                end
                PH_POLL_CMD:
                begin
                    fl_phase = PH_POLL_STAT;
                    put_byte(BYTE_DUMMY, 1'b1);
                end
                PH_POLL_STAT:
                begin
                    if (c.flash_byte[WIP_BIT])
                    begin
                        fl_phase = PH_POLL_CMD;
                        put_byte(OPC_RDSR, 1'b0);
                    end
                    else if (fl_op == ACT_PROG && fl_left != '0)
                    begin
                        open_page();
                    end
                    else
                    begin
                        finish_op();
                    end
                end
                PH_ID:
                begin
                    fl_id = {fl_id[15:0], c.flash_byte};
                    if (fl_pos < id_len())
                    begin
                        fl_pos = fl_pos + 3'd1;
                        put_byte(BYTE_DUMMY, fl_pos == id_len());
                    end
                    else
                    begin
                        fl_rsp.id_valid = 1'b1;
                        fl_rsp.id_value = (fl_op == ACT_MFR) ? {8'h00, fl_id[15:0]} : fl_id;
                        finish_op();
                    end
                end
                default:
                begin
                    // Idle, or waiting for host data: the reply is dropped.
                end
            endcase
        end
        return fl_rsp;
    endfunction

    // ------------------------------------------------------------------------
    // Word helpers
    // ------------------------------------------------------------------------
    function automatic cmd_item_t word_of(action_t a, logic [23:0] ad, logic [15:0] ln,
                                          logic [7:0] hb, logic [7:0] fb);
        cmd_item_t c;
        c.action     = a;
        c.address    = ad;
        c.length     = ln;
        c.host_byte  = hb;
        c.flash_byte = fb;
        return c;
    endfunction

    function automatic cmd_item_t random_word();
        return word_of(action_t'($urandom_range(0, 7)), 24'($urandom_range(0, 24'hFFFFFF)),
                       16'($urandom_range(0, 16'hFFFF)), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)));
    endfunction

    // Offers one word on cmd and waits for the handshake. Inputs change on
    // the falling edge; ready is sampled on the rising edge. valid is left
    // high after the handshake so that back-to-back words need no gap; a
    // caller that stops sending must lower it at the next falling edge.
    task automatic push_word(cmd_item_t c);
        rsp_item_t r;
        @(negedge clk);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            cmd_ch.valid <= 1'b0;
            @(negedge clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.data  <= c;
        do @(posedge clk); while (!cmd_ch.ready);
        r = sequence_step(c);
        rsp_due.push_back(r);
        if (r != '0)
        begin
            work_words++;
        end
    endtask

    // Stops sending and waits until every predicted word has come back.
    task automatic wait_drained();
        @(negedge clk);
        cmd_ch.valid <= 1'b0;
        while (rsp_due.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // ------------------------------------------------------------------------
    // Receiver. It stalls at random, or for hold_left cycles in a row when a
    // long stall has been asked for.
    // ------------------------------------------------------------------------
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                rsp_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Checker. Every rsp word that is taken is matched against the oldest
    // prediction, one field at a time.
    // ------------------------------------------------------------------------
    function automatic void cmp_field(string name, logic [23:0] want, logic [23:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            rsp_seen = rsp_ch.data;
            if (rsp_due.size() == 0)
            begin
                $display("%0t: unexpected rsp word, expected none, actual %p",
                         $time, rsp_seen);
                mismatches++;
            end
            else
            begin
                rsp_want = rsp_due.pop_front();
                cmp_field("send_valid", 24'(rsp_want.send_valid), 24'(rsp_seen.send_valid));
                cmp_field("out_byte",   24'(rsp_want.out_byte),   24'(rsp_seen.out_byte));
                cmp_field("frame_end",  24'(rsp_want.frame_end),  24'(rsp_seen.frame_end));
                cmp_field("want_data",  24'(rsp_want.want_data),  24'(rsp_seen.want_data));
                cmp_field("read_valid", 24'(rsp_want.read_valid), 24'(rsp_seen.read_valid));
                cmp_field("read_byte",  24'(rsp_want.read_byte),  24'(rsp_seen.read_byte));
                cmp_field("id_valid",   24'(rsp_want.id_valid),   24'(rsp_seen.id_valid));
                cmp_field("id_value",   rsp_want.id_value,        rsp_seen.id_value);
                cmp_field("done_res",   24'(rsp_want.done_res),   24'(rsp_seen.done_res));
                cmp_field("rejected",   24'(rsp_want.rejected),   24'(rsp_seen.rejected));
            end
        end
    end

    // Watchdog: a hung handshake ends the run here.
    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Flash replies and host data that arrive with nothing running must
    // leave the block idle and give an all-zero word.
    task automatic test_ignored_words();
        push_word(word_of(ACT_FLASH_REPLY, '1, '1, '1, '1));
        push_word(word_of(ACT_HOST_DATA, '0, '0, 8'hFF, 8'h00));
    endtask

    // A program of zero bytes is done at once. A read of zero bytes sends
    // only its header, which closes the frame, and the reply to the last
    // address byte finishes it.
    task automatic test_zero_length();
        push_word(word_of(ACT_PROG, 24'hFFFFFF, '0, 8'h00, 8'hFF));
        push_word(word_of(ACT_READ, 24'hFFFFFF, '0, 8'hFF, 8'h00));
        repeat (4) push_word(word_of(ACT_FLASH_REPLY, '0, '0, 8'h00, 8'h00));
    endtask

    // Manufacturer ID, with a read request refused in the middle of it, then
    // JEDEC ID with a stray host data word that must be dropped.
    task automatic test_id_reads();
        push_word(word_of(ACT_MFR, 24'h000000, '0, 8'h00, 8'h00));
        push_word(word_of(ACT_READ, '1, 16'hFFFF, 8'hFF, 8'hFF));
        repeat (4) push_word(word_of(ACT_FLASH_REPLY, '0, '0, 8'h00, 8'h00));
        push_word(word_of(ACT_FLASH_REPLY, '0, '0, 8'h00, 8'hEF));
        push_word(word_of(ACT_FLASH_REPLY, '0, '0, 8'h00, 8'h17));
        push_word(word_of(ACT_JEDEC, '1, '1, 8'h00, 8'h00));
        push_word(word_of(ACT_HOST_DATA, '0, '0, 8'hA5, 8'h00));
        push_word(word_of(ACT_FLASH_REPLY, '0, '0, 8'h00, 8'hFF));
        push_word(word_of(ACT_FLASH_REPLY, '0, '0, 8'h00, 8'hC2));
        push_word(word_of(ACT_FLASH_REPLY, '0, '0, 8'h00, 8'h20));
        push_word(word_of(ACT_FLASH_REPLY, '0, '0, 8'h00, 8'h18));
    endtask

    // Chip erase with one status poll that still shows write in progress,
    // so a second poll frame must follow, and a sector erase request that
    // arrives while it runs.
    task automatic test_erase_polling();
        push_word(word_of(ACT_CE, '0, '0, 8'h00, 8'h00));
        push_word(word_of(ACT_FLASH_REPLY, '0, '0, 8'h00, 8'hFF));
        push_word(word_of(ACT_SE, 24'h123456, 16'h8000, 8'h00, 8'h00));
        push_word(word_of(ACT_FLASH_REPLY, '0, '0, 8'h00, 8'hFF));
        push_word(word_of(ACT_FLASH_REPLY, '0, '0, 8'h00, 8'h00));
        push_word(word_of(ACT_FLASH_REPLY, '0, '0, 8'h00, 8'h01));
        push_word(word_of(ACT_FLASH_REPLY, '0, '0, 8'h00, 8'h00));
        push_word(word_of(ACT_FLASH_REPLY, '0, '0, 8'h00, 8'hFE));
    endtask

    // Random operations run to completion. Most words follow the protocol:
    // host data when the block asks for it, flash replies otherwise, with
    // the write-in-progress bit set now and then during polling. A few words
    // are random noise: refused requests, stray replies and stray data.
    // Lengths are mostly short; some programs and reads start near a page
    // end or near the top of the address space, and a rare one is over a page long.
    task automatic test_random_operations(int words);
        int        goal;
        int        r;
        cmd_item_t c;
        goal = work_words + words;
        while (work_words < goal)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                c = random_word();
                c.action = $urandom_range(0, 1) ? ACT_HOST_DATA : ACT_FLASH_REPLY;
                push_word(c);
            end
            c = random_word();
            r = $urandom_range(0, 99);
            if (r < 32)      c.action = ACT_READ;
            else if (r < 64) c.action = ACT_PROG;
            else if (r < 74) c.action = ACT_SE;
            else if (r < 80) c.action = ACT_CE;
            else if (r < 90) c.action = ACT_MFR;
            else             c.action = ACT_JEDEC;
            if (c.action == ACT_READ || c.action == ACT_PROG)
            begin
                r = $urandom_range(0, 99);
                if (r < 2)       c.length = 16'($urandom_range(257, 280));
                else if (r < 20) c.length = 16'($urandom_range(13, 40));
                else             c.length = 16'($urandom_range(0, 12));
                if ($urandom_range(0, 3) == 0)
                begin
                    c.address[7:0] = 8'($urandom_range(248, 255));
                end
                if ($urandom_range(0, 15) == 0)
                begin
                    c.address[23:8] = '1;
                end
            end
            push_word(c);
            while (fl_phase != PH_IDLE)
            begin
                c = random_word();
                if ($urandom_range(0, 99) >= 8)
                begin
                    c.action = (fl_phase == PH_DATA_WAIT) ? ACT_HOST_DATA : ACT_FLASH_REPLY;
                    if (fl_phase == PH_POLL_STAT)
                    begin
                        c.flash_byte[WIP_BIT] = ($urandom_range(0, 3) == 0);
                    end
                end
                push_word(c);
            end
        end
    endtask

    // The receiver holds off for a long stretch while the sender keeps
    // offering words, so the pipeline fills and cmd must stall.
    task automatic test_output_stall();
        hold_left = 250;
        test_random_operations(40);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        cmd_ch.valid = 1'b0;
        cmd_ch.data  = '0;
        rst_n        = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Sender idles a little, receiver a lot.
        src_idle_pct  = 23;
        sink_idle_pct = 85;
        test_ignored_words();
        test_zero_length();
        test_id_reads();
        test_erase_polling();
        test_random_operations(160);
        wait_drained();

        // Sender idles a lot, receiver a little.
        src_idle_pct  = 85;
        sink_idle_pct = 23;
        test_random_operations(160);
        test_output_stall();
        wait_drained();

        // Full rate on both sides.
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        test_random_operations(160);
        wait_drained();

        // Leave time for any stray word the block might still emit.
        repeat (8) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
